[design/foc_pkg.sv]
// ----------------------------------------------------------------------------
// foc_pkg: footstep offset clipper shared types and constants
// Coordinate width, payload structs, register map and work item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package foc_pkg;

    localparam int CW    = 16;
    localparam int REGW  = 15;
    localparam int QW    = CW - 1;
    localparam int PW    = CW + 15;
    localparam int SW    = CW + 17;
    localparam int DW    = CW + 18;
    localparam int NW    = 32;
    localparam int NPW   = 30;
    localparam int NUMW  = CW + NPW;
    localparam int DENW  = CW + 17;
    localparam int GW    = ((DW > NW) ? DW : NW) + 1;
    localparam int CMPW  = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;
    localparam int ADDRW = 5;
    localparam int DATAW = 32;
    localparam int QDEPTH = 4;

    localparam logic [2:0] REG_MIN_Y    = 3'd0;
    localparam logic [2:0] REG_MAX_Y    = 3'd1;
    localparam logic [2:0] REG_MAX_X    = 3'd2;
    localparam logic [2:0] REG_CORNER_X = 3'd3;
    localparam logic [2:0] REG_CORNER_Y = 3'd4;

    localparam logic [REGW-1:0] RST_MIN_Y    = 15'd655;
    localparam logic [REGW-1:0] RST_MAX_Y    = 15'd1229;
    localparam logic [REGW-1:0] RST_MAX_X    = 15'd1024;
    localparam logic [REGW-1:0] RST_CORNER_X = 15'd819;
    localparam logic [REGW-1:0] RST_CORNER_Y = 15'd1229;

    typedef struct packed {
        logic signed [CW-1:0] step_x;
        logic signed [CW-1:0] step_y;
    } step_in_t;

    typedef struct packed {
        logic signed [CW-1:0] clipped_x;
        logic signed [CW-1:0] clipped_y;
    } step_out_t;

    typedef struct packed {
        logic [REGW-1:0] min_y;
        logic [REGW-1:0] max_y;
        logic [REGW-1:0] max_x;
        logic [REGW-1:0] corner_x;
        logic [REGW-1:0] corner_y;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_PASS,
        OP_DIV_INNER,
        OP_DIV_OUTER
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [CW-1:0]   rx;
        logic [CW-1:0]   ry;
        logic [NUMW-1:0] num_x;
        logic [NUMW-1:0] num_y;
        logic [DENW-1:0] den;
        logic            neg_x;
        logic            neg_y;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

[design/foc_front.sv]
// ----------------------------------------------------------------------------
// foc_front: step classifier
// Four stage pipeline: magnitudes, products, sector tests, numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_front
    import foc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire step_in_t s_data,
    input  wire q_stat_t  q_stat,
    output logic          push,
    output work_t         push_data
);

    logic en;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic          nx1_reg, ny1_reg, nx2_reg, ny2_reg, nx3_reg, ny3_reg;

    logic [PW-1:0]         pa_reg, pb_reg, pc_reg, pe_reg, pb3_reg;
    logic signed [SW-1:0]  pm_reg, pf_reg;
    logic [NPW-1:0]        nf1_reg, nf2_reg, nf3_reg;

    logic                  zx_reg, flat_reg, inner_reg;
    logic signed [NW-1:0]  n_reg;
    logic signed [DW-1:0]  d_reg;
    work_t                 w_reg;

    logic [CW-1:0]         ax, ay;
    logic signed [REGW:0]  dmy, dmx;
    logic                  seg_flat;
    logic signed [NW-1:0]  n_next;
    logic signed [DW-1:0]  d_next;
    work_t                 w_next;
    logic [CW-1:0]         yclamp;

    assign en        = !(v4_reg && q_stat.full);
    assign s_ready   = en;
    assign push      = v4_reg && !q_stat.full;
    assign push_data = w_reg;

    assign ax = s_data.step_x[CW-1] ? (~s_data.step_x + 1'b1) : s_data.step_x;
    assign ay = s_data.step_y[CW-1] ? (~s_data.step_y + 1'b1) : s_data.step_y;

    assign dmy = $signed({1'b0, cfg.max_y}) - $signed({1'b0, cfg.corner_y});
    assign dmx = $signed({1'b0, cfg.max_x}) - $signed({1'b0, cfg.corner_x});

    assign seg_flat = pc_reg < pe_reg;

    always_comb begin
        if (seg_flat) begin
            n_next = $signed({2'b00, nf1_reg}) - $signed({2'b00, nf3_reg});
            d_next = DW'(pf_reg) + $signed(DW'(pe_reg)) - $signed(DW'(pb_reg));
        end else begin
            n_next = $signed({2'b00, nf2_reg});
            d_next = $signed(DW'(pc_reg)) + DW'(pm_reg);
        end
    end

    always_comb begin
        if (y3_reg < CW'(cfg.min_y)) begin
            yclamp = CW'(cfg.min_y);
        end else if (y3_reg > CW'(cfg.max_y)) begin
            yclamp = CW'(cfg.max_y);
        end else begin
            yclamp = y3_reg;
        end
    end

    always_comb begin
        w_next       = '0;
        w_next.neg_x = nx3_reg;
        w_next.neg_y = ny3_reg;
        w_next.op    = OP_PASS;
        if (zx_reg) begin
            w_next.ry = yclamp;
        end else if (flat_reg) begin
            w_next.rx = CW'(cfg.max_x);
            w_next.ry = CW'(cfg.min_y);
        end else if (inner_reg) begin
            w_next.op    = OP_DIV_INNER;
            w_next.num_x = NUMW'(pb3_reg);
            w_next.den   = DENW'(y3_reg);
            w_next.ry    = CW'(cfg.min_y);
        end else if (d_reg > $signed(DW'(0)) && GW'(d_reg) > GW'(n_reg)) begin
            if (n_reg > $signed(NW'(0))) begin
                w_next.op    = OP_DIV_OUTER;
                w_next.num_x = NUMW'(x3_reg) * NUMW'(n_reg[NPW-1:0]);
                w_next.num_y = NUMW'(y3_reg) * NUMW'(n_reg[NPW-1:0]);
                w_next.den   = d_reg[DENW-1:0];
            end
        end else begin
            w_next.rx = x3_reg;
            w_next.ry = y3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg  <= ax;
            y1_reg  <= ay;
            nx1_reg <= s_data.step_x[CW-1];
            ny1_reg <= s_data.step_y[CW-1];

            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
            pa_reg  <= PW'(y1_reg) * PW'(cfg.max_x);
            pb_reg  <= PW'(x1_reg) * PW'(cfg.min_y);
            pc_reg  <= PW'(y1_reg) * PW'(cfg.corner_x);
            pe_reg  <= PW'(x1_reg) * PW'(cfg.corner_y);
            pm_reg  <= SW'(dmy) * $signed(SW'(x1_reg));
            pf_reg  <= SW'(dmx) * $signed(SW'(y1_reg));
            nf1_reg <= NPW'(cfg.corner_y) * NPW'(cfg.max_x);
            nf2_reg <= NPW'(cfg.max_y) * NPW'(cfg.corner_x);
            nf3_reg <= NPW'(cfg.min_y) * NPW'(cfg.corner_x);

            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            pb3_reg   <= pb_reg;
            zx_reg    <= x2_reg == '0;
            flat_reg  <= pa_reg < pb_reg;
            inner_reg <= y2_reg < CW'(cfg.min_y);
            n_reg     <= n_next;
            d_reg     <= d_next;

            w_reg <= w_next;
        end
    end

endmodule

`default_nettype wire

[design/foc_queue.sv]
// ----------------------------------------------------------------------------
// foc_queue: work item queue
// Small register FIFO between the classifier and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_queue
    import foc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire work_t push_data,
    input  wire logic  pop,
    output work_t      pop_data,
    output q_stat_t    q_stat
);

    localparam int AW = $clog2(QDEPTH);

    work_t         mem_reg [QDEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign pop_data     = mem_reg[rd_reg];
    assign q_stat.full  = cnt_reg == (AW+1)'(QDEPTH);
    assign q_stat.empty = cnt_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[design/foc_div.sv]
// ----------------------------------------------------------------------------
// foc_div: pipelined saturating divider
// Restoring division, one quotient bit per stage, clamped to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_div
    import foc_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [NUMW-1:0] num_i,
    input  wire logic [DENW-1:0] den_i,
    output logic [QW-1:0]        quo_o
);

    logic [CMPW-1:0] rem_reg [QW+1];
    logic [DENW-1:0] den_reg [QW+1];
    logic [QW-1:0]   q_reg   [QW+1];
    logic            sat_reg [QW+1];

    assign quo_o = sat_reg[QW] ? '1 : q_reg[QW];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= CMPW'(num_i);
            den_reg[0] <= den_i;
            q_reg[0]   <= '0;
            sat_reg[0] <= CMPW'(num_i) >= (CMPW'(den_i) << QW);
            for (int k = 1; k <= QW; k++) begin
                den_reg[k] <= den_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                if (rem_reg[k-1] >= (CMPW'(den_reg[k-1]) << (QW - k))) begin
                    rem_reg[k] <= rem_reg[k-1] - (CMPW'(den_reg[k-1]) << (QW - k));
                    q_reg[k]   <= q_reg[k-1] | (QW'(1) << (QW - k));
                end else begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k]   <= q_reg[k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/foc_back.sv]
// ----------------------------------------------------------------------------
// foc_back: divider back end
// Two divider lanes with a side pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_back
    import foc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_stat_t q_stat,
    input  wire work_t   pop_data,
    output logic         pop,
    output logic         m_valid,
    input  wire logic    m_ready,
    output step_out_t    m_data
);

    logic          en;
    logic          v_reg [QW+1];
    work_t         side_reg [QW+1];
    logic          out_v_reg;
    step_out_t     out_reg;
    logic [QW-1:0] qx, qy;
    logic [CW-1:0] mx, my;
    work_t         tail;

    assign en      = !out_v_reg || m_ready;
    assign pop     = en && !q_stat.empty;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;
    assign tail    = side_reg[QW];

    foc_div u_div_x (
        .aclk  (aclk),
        .en    (en),
        .num_i (pop_data.num_x),
        .den_i (pop_data.den),
        .quo_o (qx)
    );

    foc_div u_div_y (
        .aclk  (aclk),
        .en    (en),
        .num_i (pop_data.num_y),
        .den_i (pop_data.den),
        .quo_o (qy)
    );

    always_comb begin
        unique case (tail.op)
            OP_PASS: begin
                mx = tail.rx;
                my = tail.ry;
            end
            OP_DIV_INNER: begin
                mx = CW'(qx);
                my = tail.ry;
            end
            OP_DIV_OUTER: begin
                mx = CW'(qx);
                my = CW'(qy);
            end
            default: begin
                mx = tail.rx;
                my = tail.ry;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg[0] <= pop;
            for (int k = 1; k <= QW; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            out_v_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= pop_data;
            for (int k = 1; k <= QW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            out_reg.clipped_x <= tail.neg_x ? (~mx + 1'b1) : mx;
            out_reg.clipped_y <= tail.neg_y ? (~my + 1'b1) : my;
        end
    end

endmodule

`default_nettype wire

[design/footstep_offset_clipper_core.sv]
// ----------------------------------------------------------------------------
// footstep_offset_clipper_core: footstep offset clipper top level
// Clips a signed step offset into the feasible region along its ray.
// ----------------------------------------------------------------------------
//  channel  | ports                           | transfer
//  s_       | s_valid s_ready s_data          | one step request
//  m_       | m_valid m_ready m_data          | one clipped step
//  APB      | psel penable pwrite paddr ...   | one register write/read
//
//  One item per cycle while the output is not stalled; path: four classifier
//  stages, queue entry, a CW-stage pipelined divider pair, output register.
//  Synchronous active-low reset clears all valid flags and the queue.
//  An output stall freezes the back end; the four-entry queue keeps the
//  front end running until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module footstep_offset_clipper_core
    import foc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire step_in_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output step_out_t             m_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [ADDRW-1:0] paddr,
    input  wire logic [DATAW-1:0] pwdata,
    output logic [DATAW-1:0]      prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;
    q_stat_t    q_stat;
    logic       push, pop;
    work_t      push_data, pop_data;

    assign pready = 1'b1;
    assign idx    = paddr[ADDRW-1:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_y    <= RST_MIN_Y;
            cfg_reg.max_y    <= RST_MAX_Y;
            cfg_reg.max_x    <= RST_MAX_X;
            cfg_reg.corner_x <= RST_CORNER_X;
            cfg_reg.corner_y <= RST_CORNER_Y;
        end else if (wr_en) begin
            unique case (idx)
                REG_MIN_Y:    cfg_reg.min_y    <= pwdata[REGW-1:0];
                REG_MAX_Y:    cfg_reg.max_y    <= pwdata[REGW-1:0];
                REG_MAX_X:    cfg_reg.max_x    <= pwdata[REGW-1:0];
                REG_CORNER_X: cfg_reg.corner_x <= pwdata[REGW-1:0];
                REG_CORNER_Y: cfg_reg.corner_y <= pwdata[REGW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MIN_Y:    prdata = DATAW'(cfg_reg.min_y);
            REG_MAX_Y:    prdata = DATAW'(cfg_reg.max_y);
            REG_MAX_X:    prdata = DATAW'(cfg_reg.max_x);
            REG_CORNER_X: prdata = DATAW'(cfg_reg.corner_x);
            REG_CORNER_Y: prdata = DATAW'(cfg_reg.corner_y);
            default:      prdata = '0;
        endcase
    end

    foc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    foc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    foc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_stall_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !pop)
        else $error("queue popped while output stalled");

endmodule

`default_nettype wire

[dv/foc_checker.sv]
// ----------------------------------------------------------------------------
// foc_checker: clipped step scoreboard
// Watches both step channels, predicts each clipped step from the register
// shadow and compares every m_ transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module foc_checker
    import foc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  step_in_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  step_out_t m_data,
    input  cfg_t      cfg,
    output int        fail_count,
    output int        pending
);

    step_out_t clipped_q[$];

    function automatic longint quot_sat(longint n, longint d);
        longint q;
        longint m;
        m = (64'sd1 <<< (CW - 1)) - 1;
        if (d <= 0) return m;
        if (n <= 0) return 0;
        q = n / d;
        return (q > m) ? m : q;
    endfunction

    function automatic step_out_t clip_step(step_in_t s);
        longint sx, sy, x0, y0, rx, ry, n, d;
        longint mny, mxy, mxx, cx, cy;
        step_out_t r;
        mny = cfg.min_y; mxy = cfg.max_y; mxx = cfg.max_x;
        cx = cfg.corner_x; cy = cfg.corner_y;
        sx = s.step_x;
        sy = s.step_y;
        x0 = (sx < 0) ? -sx : sx;
        y0 = (sy < 0) ? -sy : sy;
        if (x0 == 0) begin
            rx = 0;
            if (y0 < mny) ry = mny;
            else if (y0 > mxy) ry = mxy;
            else ry = y0;
        end else if (y0 * mxx < mny * x0) begin
            rx = mxx;
            ry = mny;
        end else if (y0 < mny) begin
            rx = quot_sat(mny * x0, y0);
            ry = mny;
        end else begin
            if (y0 * cx < cy * x0) begin
                n = cy * mxx - mny * cx;
                d = y0 * (mxx - cx) + (cy - mny) * x0;
            end else begin
                n = mxy * cx;
                d = y0 * cx + (mxy - cy) * x0;
            end
            if (d > 0 && d > n) begin
                rx = quot_sat(x0 * n, d);
                ry = quot_sat(y0 * n, d);
            end else begin
                rx = x0;
                ry = y0;
            end
        end
        r.clipped_x = (sx < 0) ? CW'(-rx) : CW'(rx);
        r.clipped_y = (sy < 0) ? CW'(-ry) : CW'(ry);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = clipped_q.size();

    always @(posedge aclk) begin
        step_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) clipped_q.push_back(clip_step(s_data));
            if (m_valid && m_ready) begin
                if (clipped_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    want = clipped_q.pop_front();
                    if (m_data.clipped_x !== want.clipped_x)
                        report_mismatch("clipped_x", m_data.clipped_x, want.clipped_x);
                    if (m_data.clipped_y !== want.clipped_y)
                        report_mismatch("clipped_y", m_data.clipped_y, want.clipped_y);
                end
            end
        end
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: footstep offset clipper top-level test
// Directed and random steps across several register settings, with random
// gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import foc_pkg::*;

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_valid = 0;
    logic             s_ready;
    step_in_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 0;
    step_out_t        m_data;
    logic             psel = 0;
    logic             penable = 0;
    logic             pwrite = 0;
    logic [ADDRW-1:0] paddr = '0;
    logic [DATAW-1:0] pwdata = '0;
    logic [DATAW-1:0] prdata;
    logic             pready;
    cfg_t             cfg;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               hold_off = 0;
    bit               done = 0;

    localparam int IDLE_LIMIT = 20000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    footstep_offset_clipper_core uut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    foc_checker checker_i (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .cfg, .fail_count, .pending
    );

    task automatic write_reg(logic [2:0] idx, logic [REGW-1:0] val);
        @(negedge aclk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = ADDRW'(idx) << 2; pwdata = 32'(val);
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_MIN_Y:    cfg.min_y = val;
            REG_MAX_Y:    cfg.max_y = val;
            REG_MAX_X:    cfg.max_x = val;
            REG_CORNER_X: cfg.corner_x = val;
            default:      cfg.corner_y = val;
        endcase
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic set_regions(int mny, int mxy, int mxx, int cx, int cy);
        write_reg(REG_MIN_Y, REGW'(mny));
        write_reg(REG_MAX_Y, REGW'(mxy));
        write_reg(REG_MAX_X, REGW'(mxx));
        write_reg(REG_CORNER_X, REGW'(cx));
        write_reg(REG_CORNER_Y, REGW'(cy));
    endtask

    task automatic send_step(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge aclk);
        s_valid = 1;
        s_data.step_x = x;
        s_data.step_y = y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 0;
    endtask

    function automatic logic signed [CW-1:0] rand_coord(int scale);
        case ($urandom_range(0, 4))
            0: return CW'($urandom);
            1: return CW'(-32768 + $urandom_range(0, 3));
            2: return CW'(32767 - $urandom_range(0, 3));
            default: return CW'(int'($urandom_range(0, scale)) * ($urandom_range(0, 1) ? 1 : -1));
        endcase
    endfunction

    task automatic drain;
        while (pending != 0) @(posedge aclk);
        repeat (CW + 12) @(posedge aclk);
    endtask

    task automatic random_steps(int count, int scale);
        repeat (count) begin
            if ($urandom_range(0, 15) == 0) send_step(0, rand_coord(scale));
            else send_step(rand_coord(scale), rand_coord(scale));
        end
    endtask

    // receiver: random gaps, or a long hold-off when requested
    always @(negedge aclk) begin
        int wait_n;
        if (!aresetn) begin
            m_ready <= 0;
        end else if (hold_off) begin
            m_ready <= 0;
            repeat (60) @(negedge aclk);
            hold_off = 0;
        end else if (m_ready && m_valid) begin
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0) begin
                m_ready <= 0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1;
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        cfg = '{RST_MIN_Y, RST_MAX_Y, RST_MAX_X, RST_CORNER_X, RST_CORNER_Y};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // reset settings: axis, sectors, extremes
        send_step(0, 0);
        send_step(0, 100);
        send_step(0, 5000);
        send_step(0, -32768);
        send_step(1000, 10);
        send_step(-32768, 0);
        send_step(32767, -32768);
        send_step(500, 300);
        send_step(-500, -2000);
        send_step(200, 900);
        send_step(2000, 2500);
        send_step(-300, 700);
        send_step(100, 1100);
        send_step(-32768, -32768);
        send_step(32767, 32767);
        send_step(1, 1);
        send_step(-1, 32767);
        drain();

        // inconsistent and extreme registers
        set_regions(32767, 0, 1, 1, 0);
        send_step(0, 10); send_step(100, 32767); send_step(-32768, 5);
        send_step(7, -32768);
        drain();
        set_regions(0, 32767, 32767, 32767, 32767);
        send_step(0, 10); send_step(3000, 100); send_step(-32768, -32768);
        send_step(5, 32000);
        drain();

        set_regions(655, 1229, 1024, 819, 1229);
        random_steps(350, 3000);
        hold_off = 1;
        random_steps(40, 3000);
        drain();
        set_regions(0, 0, 32767, 1, 0);
        random_steps(200, 32767);
        drain();
        set_regions(32767, 32767, 32767, 32767, 32767);
        random_steps(200, 32767);
        drain();
        set_regions($urandom_range(0, 800), $urandom_range(800, 3000), $urandom_range(1, 2000),
                    $urandom_range(1, 2000), $urandom_range(0, 3000));
        random_steps(300, 4000);
        drain();
        set_regions($urandom & 32'h7fff, $urandom & 32'h7fff, $urandom_range(1, 32767),
                    $urandom_range(1, 32767), $urandom & 32'h7fff);
        random_steps(280, 32767);
        drain();

        done = 1;
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
